@@ sv/multichannel_input_debouncer_core_defines.svh @@
// Assertion macros shared by the debouncer checker.
`ifndef MULTICHANNEL_INPUT_DEBOUNCER_CORE_DEFINES_SVH
`define MULTICHANNEL_INPUT_DEBOUNCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MID_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("debouncer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("debouncer assertion failed");

`endif

@@ sv/mid_pkg.sv @@
// Package with the constants and types of the multichannel input debouncer.
`timescale 1ns / 1ps
package mid_pkg;

   // Channel count and field widths.
   localparam int CHANNELS    = 16;
   localparam int LEVEL_W     = 16;
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 16;

   // Stream data widths.
   localparam int REQ_DATA_W  = LEVEL_W + TIME_W;
   localparam int RSP_DATA_W  = 3 * LEVEL_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TIME = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MANUAL_MODE   = 2'd1;

   // Reset values of the registers.
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

   // Controls shared by every channel lane.
   typedef struct packed {
      logic                  accept;
      logic                  started;
      logic [DEBOUNCE_W-1:0] debounce_time;
   } lane_ctl_type;

endpackage

@@ sv/mid_lane.sv @@
// One debounce channel: raw level, accepted level and time of last raw change.
`timescale 1ns / 1ps
module mid_lane (
   input  logic                      clock,
   input  mid_pkg::lane_ctl_type     ctl,
   input  logic                      raw_level,
   input  logic [mid_pkg::TIME_W-1:0] now_time,
   output logic                      stable_next,
   output logic                      rise
);
   import mid_pkg::*;

   logic              last_raw_ff, last_raw_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic [TIME_W-1:0] base_time;
   logic [TIME_W-1:0] held;
   logic              take;

   // A raw change restarts the hold timer at this sample's time.
   always_comb begin
      base_time = (raw_level != last_raw_ff) ? now_time : change_time_ff;
      held      = now_time - base_time;
      take      = (raw_level != stable_ff) &&
                  (held >= {{(TIME_W-DEBOUNCE_W){1'b0}}, ctl.debounce_time});
   end

   // The first sample after reset only loads the state.
   always_comb begin
      last_raw_in = raw_level;
      if (!ctl.started) begin
         stable_in      = raw_level;
         change_time_in = now_time;
         rise           = 1'b0;
      end else begin
         stable_in      = take ? raw_level : stable_ff;
         change_time_in = base_time;
         rise           = take & raw_level;
      end
   end

   assign stable_next = stable_in;

   // Channel state moves on with every accepted item.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

@@ sv/multichannel_input_debouncer_core.sv @@
// Top level of the multichannel input debouncer.
// Each item carries one sample of 16 input levels and a millisecond timestamp; the
// block answers every item with exactly one result: the debounced levels after the
// sample, the channels that went stably high, and the same mask as relay toggle
// requests when manual mode is set. It takes one item per clock unless a result
// is stalled; the result is registered and appears in the cycle after acceptance,
// via one 32-bit subtract and compare per channel, all in parallel. The first item
// after reset only loads the channel state. The always-ready csr_ port takes
// configuration, written by the user only while no item is in flight (unenforced).
`timescale 1ns / 1ps
module multichannel_input_debouncer_core (
   input  logic                               clock,
   input  logic                               reset,
   // Input items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // raw_inputs [15:0], now_time [47:16]
   input  logic [mid_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // debounced_inputs [15:0], rising_edges [31:16], toggle_requests [47:32]
   output logic [mid_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mid_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mid_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mid_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_time_ff, debounce_time_in;
   logic                  manual_mode_ff, manual_mode_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  accept;
   lane_ctl_type          lane_ctl;
   logic [LEVEL_W-1:0]    raw_levels;
   logic [TIME_W-1:0]     now_time;
   logic [LEVEL_W-1:0]    stable_next;
   logic [LEVEL_W-1:0]    rising;

   // Input side: a new item whenever the result register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign raw_levels = req_tdata[LEVEL_W-1:0];
   assign now_time   = req_tdata[LEVEL_W +: TIME_W];

   assign lane_ctl.accept        = accept;
   assign lane_ctl.started       = started_ff;
   assign lane_ctl.debounce_time = debounce_time_ff;

   // One lane per channel; unused channels read as zero.
   genvar gi;
   generate
      for (gi = 0; gi < CHANNELS; gi++) begin : g_lane
         mid_lane u_lane (
            .clock       (clock),
            .ctl         (lane_ctl),
            .raw_level   (raw_levels[gi]),
            .now_time    (now_time),
            .stable_next (stable_next[gi]),
            .rise        (rising[gi])
         );
      end
      for (gi = CHANNELS; gi < LEVEL_W; gi++) begin : g_unused
         assign stable_next[gi] = 1'b0;
         assign rising[gi]      = 1'b0;
      end
   endgenerate

   // Configuration register decode; unknown indexes are ignored.
   assign csr_ready = 1'b1;
   always_comb begin
      debounce_time_in = debounce_time_ff;
      manual_mode_in   = manual_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TIME: debounce_time_in = csr_data[DEBOUNCE_W-1:0];
            CSR_MANUAL_MODE:   manual_mode_in   = csr_data[0];
            default:           ;
         endcase
      end
   end

   // Start flag and result register.
   always_comb begin
      started_in   = started_ff | accept;
      rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = {(manual_mode_ff ? rising : {LEVEL_W{1'b0}}), rising, stable_next};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= DEBOUNCE_RESET;
         manual_mode_ff   <= 1'b0;
         started_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         debounce_time_ff <= debounce_time_in;
         manual_mode_ff   <= manual_mode_in;
         started_ff       <= started_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/mid_checker.sv @@
// Port-level checker for the debouncer, bound to the top level.
`timescale 1ns / 1ps
`include "multichannel_input_debouncer_core_defines.svh"
module mid_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [mid_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import mid_pkg::*;

   logic [LEVEL_W-1:0] debounced;
   logic [LEVEL_W-1:0] rising;
   logic [LEVEL_W-1:0] toggles;

   assign debounced = rsp_tdata[LEVEL_W-1:0];
   assign rising    = rsp_tdata[LEVEL_W +: LEVEL_W];
   assign toggles   = rsp_tdata[2*LEVEL_W +: LEVEL_W];

   // A rising edge always leaves its channel high.
   `MID_ASSERT_NOW(a_rise_high, clock, reset, rsp_tvalid, (rising & ~debounced) == '0)

   // Toggle requests are only ever a subset of the rising edges.
   `MID_ASSERT_NOW(a_toggle_sub, clock, reset, rsp_tvalid, (toggles & ~rising) == '0)

   // Every accepted item shows a result in the next cycle.
   `MID_ASSERT_NEXT(a_one_result, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // A stalled result stays put.
   `MID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

endmodule

bind multichannel_input_debouncer_core mid_checker u_mid_checker (.*);
